@@ sv/vlp_pkg.sv @@
`default_nettype none
package vlp_pkg;

	localparam int MAX_BITS = 64;
	localparam int VALUE_W = 64;
	localparam int WIDTH_W = 7;
	localparam int WACC_W = 8;
	localparam int CHAR_W = 8;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_TICK = 8'h27;
	localparam logic [CHAR_W-1:0] CH_B = 8'h62;
	localparam logic [CHAR_W-1:0] CH_O = 8'h6F;
	localparam logic [CHAR_W-1:0] CH_D = 8'h64;
	localparam logic [CHAR_W-1:0] CH_H = 8'h68;
	localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ = 8'h5A;

	localparam logic [WIDTH_W-1:0] PLAIN_WIDTH_RST = 7'd32;

	typedef enum logic [1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_DEC = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_BASE   = 2'd1,
		PH_DIGITS = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		BASE_NONE = 3'd0,
		BASE_BIN  = 3'd1,
		BASE_OCT  = 3'd2,
		BASE_DEC  = 3'd3,
		BASE_HEX  = 3'd4
	} base_t;

	typedef enum logic [1:0] {
		ERR_OK      = 2'd0,
		ERR_WIDTH   = 2'd1,
		ERR_NO_BASE = 2'd2
	} err_t;

	typedef enum logic [0:0] {
		REG_PLAIN_WIDTH = 1'b0,
		REG_PLAIN_BASE  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] plain_width;
		radix_t             plain_base;
	} cfg_t;

	// digit value of an ascii char in base 36, 63 when not alphanumeric
	function automatic logic [5:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		begin
			d = 8'hFF;
			if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
			end else if (c >= CH_LA && c <= CH_LZ) begin
				d = c - CH_LA + 8'd10;
			end else if (c >= CH_UA && c <= CH_UZ) begin
				d = c - CH_UA + 8'd10;
			end
			return d[5:0];
		end
	endfunction

	function automatic logic [4:0] radix_value(input radix_t r);
		logic [4:0] v;
		begin
			unique case (r)
				RADIX_BIN: v = 5'd2;
				RADIX_OCT: v = 5'd8;
				RADIX_DEC: v = 5'd10;
				RADIX_HEX: v = 5'd16;
				default:   v = 5'd10;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

@@ sv/vlp_ifs.sv @@
`default_nettype none
interface vlp_char_if;
	logic                      valid;
	logic                      ready;
	logic [vlp_pkg::CHAR_W-1:0] char_code;
	logic                      last;

	modport source(output valid, output char_code, output last, input ready);
	modport sink(input valid, input char_code, input last, output ready);
endinterface

interface vlp_result_if;
	logic                        valid;
	logic                        ready;
	logic [vlp_pkg::VALUE_W-1:0] value;
	logic [vlp_pkg::WIDTH_W-1:0] bit_width;
	logic [1:0]                  error_code;

	modport source(output valid, output value, output bit_width, output error_code,
		input ready);
	modport sink(input valid, input value, input bit_width, input error_code,
		output ready);
endinterface
`default_nettype wire

@@ sv/vlp_accum.sv @@
`default_nettype none
module vlp_accum (
	input  wire logic [vlp_pkg::VALUE_W-1:0] acc,
	input  wire vlp_pkg::radix_t             radix,
	input  wire logic [3:0]                  digit,
	output logic [vlp_pkg::VALUE_W-1:0]      sum
);

	// four guard bits catch overflow for any radix up to 16
	logic [vlp_pkg::VALUE_W+3:0] wide;
	logic [vlp_pkg::VALUE_W+3:0] scaled;
	logic [vlp_pkg::VALUE_W+3:0] total;

	assign wide = {4'b0, acc};

	always_comb begin
		unique case (radix)
			vlp_pkg::RADIX_BIN: scaled = wide << 1;
			vlp_pkg::RADIX_OCT: scaled = wide << 3;
			vlp_pkg::RADIX_DEC: scaled = (wide << 3) + (wide << 1);
			vlp_pkg::RADIX_HEX: scaled = wide << 4;
			default:            scaled = wide << 4;
		endcase
	end

	assign total = scaled + {{vlp_pkg::VALUE_W{1'b0}}, digit};
	assign sum = (total[vlp_pkg::VALUE_W+3:vlp_pkg::VALUE_W] != 4'b0) ?
		{vlp_pkg::VALUE_W{1'b1}} : total[vlp_pkg::VALUE_W-1:0];

endmodule
`default_nettype wire

@@ sv/vlp_regs.sv @@
`default_nettype none
module vlp_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [vlp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [vlp_pkg::DATA_W-1:0] pwdata,
	output logic [vlp_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	output vlp_pkg::cfg_t                   cfg
);

	logic [vlp_pkg::WIDTH_W-1:0] plain_width_q;
	vlp_pkg::radix_t             plain_base_q;
	vlp_pkg::reg_idx_t           idx;
	logic                        wr_en;

	assign pready = 1'b1;
	assign idx = vlp_pkg::reg_idx_t'(paddr[2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_width_q <= vlp_pkg::PLAIN_WIDTH_RST;
			plain_base_q <= vlp_pkg::RADIX_DEC;
		end else if (wr_en) begin
			unique case (idx)
				vlp_pkg::REG_PLAIN_WIDTH: plain_width_q <= pwdata[vlp_pkg::WIDTH_W-1:0];
				vlp_pkg::REG_PLAIN_BASE:  plain_base_q <= vlp_pkg::radix_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			vlp_pkg::REG_PLAIN_WIDTH:
				prdata = {{(vlp_pkg::DATA_W-vlp_pkg::WIDTH_W){1'b0}}, plain_width_q};
			vlp_pkg::REG_PLAIN_BASE:
				prdata = {{(vlp_pkg::DATA_W-2){1'b0}}, plain_base_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.plain_width = plain_width_q;
	assign cfg.plain_base = plain_base_q;

endmodule
`default_nettype wire

@@ sv/vlp_scan.sv @@
`default_nettype none
module vlp_scan (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire vlp_pkg::cfg_t cfg,
	vlp_char_if.sink        in,
	vlp_result_if.source    out
);

	// input register
	logic                        valid_s1;
	logic [vlp_pkg::CHAR_W-1:0]  char_s1;
	logic                        last_s1;

	// parse state
	vlp_pkg::phase_t             phase_q, phase_d;
	logic [vlp_pkg::WACC_W-1:0]  width_acc_q, width_acc_d;
	logic                        width_stopped_q, width_stopped_d;
	logic [vlp_pkg::VALUE_W-1:0] prefix_value_q, prefix_value_d;
	logic                        prefix_stopped_q, prefix_stopped_d;
	vlp_pkg::base_t              base_sel_q, base_sel_d;
	logic [vlp_pkg::VALUE_W-1:0] value_acc_q, value_acc_d;
	logic                        value_stopped_q, value_stopped_d;

	// result register
	logic                        out_valid_q;
	logic [vlp_pkg::VALUE_W-1:0] value_q;
	logic [vlp_pkg::WIDTH_W-1:0] bit_width_q;
	vlp_pkg::err_t               err_q;

	logic                        advance;
	logic                        fire;
	logic [5:0]                  dig;
	vlp_pkg::radix_t             sel_radix;
	vlp_pkg::radix_t             acc_radix;
	logic [vlp_pkg::VALUE_W-1:0] acc_in;
	logic [vlp_pkg::VALUE_W-1:0] acc_sum;
	logic                        dig_ok;
	logic [11:0]                 wsum;

	logic [vlp_pkg::WACC_W-1:0]  res_w;
	logic [vlp_pkg::VALUE_W-1:0] res_v;
	vlp_pkg::err_t               res_err;
	logic [vlp_pkg::VALUE_W-1:0] res_mask;
	logic [vlp_pkg::WIDTH_W-1:0] mask_shift;

	assign advance = !out_valid_q || out.ready;
	assign fire = valid_s1 && advance;
	assign in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			char_s1 <= in.char_code;
			last_s1 <= in.last;
		end
	end

	// one shared multiply-add: prefix digits in the default base, or digits after the base char
	always_comb begin
		unique case (base_sel_q)
			vlp_pkg::BASE_BIN: sel_radix = vlp_pkg::RADIX_BIN;
			vlp_pkg::BASE_OCT: sel_radix = vlp_pkg::RADIX_OCT;
			vlp_pkg::BASE_DEC: sel_radix = vlp_pkg::RADIX_DEC;
			vlp_pkg::BASE_HEX: sel_radix = vlp_pkg::RADIX_HEX;
			default:           sel_radix = vlp_pkg::RADIX_HEX;
		endcase
	end

	assign dig = vlp_pkg::digit_of(char_s1);
	assign acc_radix = (phase_q == vlp_pkg::PH_PREFIX) ? cfg.plain_base : sel_radix;
	assign acc_in = (phase_q == vlp_pkg::PH_PREFIX) ? prefix_value_q : value_acc_q;
	assign dig_ok = dig < {1'b0, vlp_pkg::radix_value(acc_radix)};

	vlp_accum u_accum (
		.acc   (acc_in),
		.radix (acc_radix),
		.digit (dig[3:0]),
		.sum   (acc_sum)
	);

	assign wsum = ({4'b0, width_acc_q} << 3) + ({4'b0, width_acc_q} << 1) + {8'b0, dig[3:0]};

	// next state for one character, before the end-of-literal clear
	always_comb begin
		phase_d = phase_q;
		width_acc_d = width_acc_q;
		width_stopped_d = width_stopped_q;
		prefix_value_d = prefix_value_q;
		prefix_stopped_d = prefix_stopped_q;
		base_sel_d = base_sel_q;
		value_acc_d = value_acc_q;
		value_stopped_d = value_stopped_q;
		if (char_s1 != vlp_pkg::CH_UNDERSCORE) begin
			unique case (phase_q)
				vlp_pkg::PH_PREFIX: begin
					if (char_s1 == vlp_pkg::CH_TICK) begin
						phase_d = vlp_pkg::PH_BASE;
					end else begin
						if (!width_stopped_q) begin
							if (dig >= 6'd10) begin
								width_stopped_d = 1'b1;
							end else begin
								width_acc_d = (wsum > 12'd255) ? 8'hFF : wsum[7:0];
							end
						end
						if (!prefix_stopped_q) begin
							if (!dig_ok) begin
								prefix_stopped_d = 1'b1;
							end else begin
								prefix_value_d = acc_sum;
							end
						end
					end
				end
				vlp_pkg::PH_BASE: begin
					priority if (char_s1 == vlp_pkg::CH_B) base_sel_d = vlp_pkg::BASE_BIN;
					else if (char_s1 == vlp_pkg::CH_O) base_sel_d = vlp_pkg::BASE_OCT;
					else if (char_s1 == vlp_pkg::CH_D) base_sel_d = vlp_pkg::BASE_DEC;
					else if (char_s1 == vlp_pkg::CH_H) base_sel_d = vlp_pkg::BASE_HEX;
					else base_sel_d = vlp_pkg::BASE_NONE;
					phase_d = vlp_pkg::PH_DIGITS;
				end
				default: begin
					if (base_sel_q != vlp_pkg::BASE_NONE && !value_stopped_q) begin
						if (!dig_ok) begin
							value_stopped_d = 1'b1;
						end else begin
							value_acc_d = acc_sum;
						end
					end
				end
			endcase
		end
	end

	// result from the updated state
	always_comb begin
		if (phase_d == vlp_pkg::PH_PREFIX) begin
			res_w = {1'b0, cfg.plain_width};
			res_v = prefix_value_d;
		end else begin
			res_w = width_acc_d;
			res_v = (base_sel_d != vlp_pkg::BASE_NONE) ? value_acc_d : '0;
		end
		priority if (phase_d == vlp_pkg::PH_BASE) begin
			res_err = vlp_pkg::ERR_NO_BASE;
		end else if (res_w == '0 || res_w > vlp_pkg::WACC_W'(vlp_pkg::MAX_BITS)) begin
			res_err = vlp_pkg::ERR_WIDTH;
		end else begin
			res_err = vlp_pkg::ERR_OK;
		end
		mask_shift = vlp_pkg::WIDTH_W'(vlp_pkg::VALUE_W) - res_w[vlp_pkg::WIDTH_W-1:0];
		res_mask = {vlp_pkg::VALUE_W{1'b1}} >> mask_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vlp_pkg::PH_PREFIX;
			width_acc_q <= '0;
			width_stopped_q <= 1'b0;
			prefix_value_q <= '0;
			prefix_stopped_q <= 1'b0;
			base_sel_q <= vlp_pkg::BASE_NONE;
			value_acc_q <= '0;
			value_stopped_q <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				phase_q <= vlp_pkg::PH_PREFIX;
				width_acc_q <= '0;
				width_stopped_q <= 1'b0;
				prefix_value_q <= '0;
				prefix_stopped_q <= 1'b0;
				base_sel_q <= vlp_pkg::BASE_NONE;
				value_acc_q <= '0;
				value_stopped_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				width_acc_q <= width_acc_d;
				width_stopped_q <= width_stopped_d;
				prefix_value_q <= prefix_value_d;
				prefix_stopped_q <= prefix_stopped_d;
				base_sel_q <= base_sel_d;
				value_acc_q <= value_acc_d;
				value_stopped_q <= value_stopped_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			err_q <= res_err;
			if (res_err == vlp_pkg::ERR_OK) begin
				value_q <= res_v & res_mask;
				bit_width_q <= res_w[vlp_pkg::WIDTH_W-1:0];
			end else begin
				value_q <= '0;
				bit_width_q <= '0;
			end
		end
	end

	assign out.valid = out_valid_q;
	assign out.value = value_q;
	assign out.bit_width = bit_width_q;
	assign out.error_code = err_q;

endmodule
`default_nettype wire

@@ sv/verilog_literal_parser_unit.sv @@
// verilog number literal parser
// in: one ascii char per word (char_code) with last marking the final char of a literal;
//   underscores are skipped, a tick splits a decimal width from a base char and digits
// out: one word per literal: value masked to the width, bit_width, error_code
//   (0 ok, 1 width out of range, 2 missing base char); value and width are zero on error
// apb port: plain_width at 0x0, plain_base at 0x4; write only while no literal is open
// throughput: one char per cycle, set by the single-cycle update of the parse state
//   through one shared 68-bit multiply-add by a constant radix
// latency: the result word is valid one cycle after the last char is accepted
//   (input register, then the result register)
// stall: a waiting result is held in the output register; the char in the input
//   register then waits unparsed and in.ready stays low until the result is taken
// reset: parse state clears to the width prefix, plain width 32, plain base decimal,
//   no result pending
`default_nettype none
module verilog_literal_parser_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	vlp_char_if.sink                        in,
	vlp_result_if.source                    out,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [vlp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [vlp_pkg::DATA_W-1:0] pwdata,
	output logic [vlp_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);

	vlp_pkg::cfg_t cfg;

	vlp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vlp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in     (in),
		.out    (out)
	);

endmodule
`default_nettype wire

@@ sv/vlp_checker.sv @@
`default_nettype none
module vlp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [vlp_pkg::VALUE_W-1:0] out_value,
	input wire logic [vlp_pkg::WIDTH_W-1:0] out_bit_width,
	input wire logic [1:0]                  out_error_code
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) &&
		$stable(out_bit_width) && $stable(out_error_code))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error_code != vlp_pkg::ERR_OK |->
		out_value == '0 && out_bit_width == '0 &&
		(out_error_code == vlp_pkg::ERR_WIDTH || out_error_code == vlp_pkg::ERR_NO_BASE))
		else $error("error result with nonzero payload or bad code");

	a_ok_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error_code == vlp_pkg::ERR_OK |->
		out_bit_width != '0 && out_bit_width <= vlp_pkg::WIDTH_W'(vlp_pkg::MAX_BITS))
		else $error("ok result with width out of range");

	a_value_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error_code == vlp_pkg::ERR_OK &&
		out_bit_width < vlp_pkg::WIDTH_W'(vlp_pkg::VALUE_W) |->
		(out_value >> out_bit_width) == '0)
		else $error("value wider than its width");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind verilog_literal_parser_unit vlp_checker u_vlp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in.ready),
	.out_valid      (out.valid),
	.out_ready      (out.ready),
	.out_value      (out.value),
	.out_bit_width  (out.bit_width),
	.out_error_code (out.error_code)
);
`default_nettype wire

@@ tb/verilog_literal_parser_unit_tb.sv @@
module verilog_literal_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vlp_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_word_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [WIDTH_W-1:0] bit_width;
		logic [1:0]         err;
	} literal_result_t;

	localparam int N_PHASES = 8;
	localparam logic [WIDTH_W-1:0] PHASE_WIDTH [N_PHASES] =
		'{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd7, 7'd16, 7'd32};
	localparam radix_t PHASE_BASE [N_PHASES] = '{RADIX_BIN, RADIX_HEX, RADIX_OCT, RADIX_DEC,
		RADIX_BIN, RADIX_HEX, RADIX_OCT, RADIX_DEC};
	localparam logic [CHAR_W-1:0] BASE_CHARS [4] = '{CH_B, CH_O, CH_D, CH_H};
	localparam int BASE_RADIX [4] = '{2, 8, 10, 16};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	vlp_char_if chars();
	vlp_result_if results();

	verilog_literal_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(chars),
		.out(results),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// words waiting to be driven and results still owed by the block
	char_word_t char_queue[$];
	literal_result_t expected_literals[$];

	bit running;
	bit quiet;
	bit char_taken;
	int idle_odds = 8;
	int send_gap;
	int stall_left;
	int bad_count;

	// settings as the block should hold them
	logic [WIDTH_W-1:0] cfg_width = PLAIN_WIDTH_RST;
	radix_t cfg_base = RADIX_DEC;

	// parse state of the open literal
	phase_t lit_phase = PH_PREFIX;
	int width_sum;
	bit width_done;
	logic [VALUE_W-1:0] plain_value;
	bit plain_done;
	base_t lit_base = BASE_NONE;
	logic [VALUE_W-1:0] sized_value;
	bit sized_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int radix_of_default(radix_t r);
		case (r)
			RADIX_BIN: return 2;
			RADIX_OCT: return 8;
			RADIX_DEC: return 10;
			default:   return 16;
		endcase
	endfunction

	function automatic int radix_of_sel(base_t b);
		case (b)
			BASE_BIN: return 2;
			BASE_OCT: return 8;
			BASE_DEC: return 10;
			BASE_HEX: return 16;
			default:  return 0;
		endcase
	endfunction

	// -1 when c is no digit of this radix
	function automatic int char_digit(logic [CHAR_W-1:0] c, int radix);
		int d;
		if (c >= CH_0 && c <= CH_9) d = c - CH_0;
		else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + 10;
		else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + 10;
		else return -1;
		return (d < radix) ? d : -1;
	endfunction

	// acc * radix + d, stuck at all ones once it would overflow
	function automatic logic [VALUE_W-1:0] mac_sat(logic [VALUE_W-1:0] acc, int radix, int d);
		logic [VALUE_W-1:0] lim;
		lim = ({VALUE_W{1'b1}} - VALUE_W'(d)) / VALUE_W'(radix);
		if (acc > lim) return {VALUE_W{1'b1}};
		return acc * VALUE_W'(radix) + VALUE_W'(d);
	endfunction

	function automatic void parse_literal_char(logic [CHAR_W-1:0] c, logic fin);
		int dw;
		int dv;
		int r;
		int w;
		logic [VALUE_W-1:0] v;
		err_t err;
		literal_result_t res;
		if (c != CH_UNDERSCORE) begin
			case (lit_phase)
				PH_PREFIX: begin
					if (c == CH_TICK) begin
						lit_phase = PH_BASE;
					end else begin
						r = radix_of_default(cfg_base);
						dw = char_digit(c, 10);
						dv = char_digit(c, r);
						if (!width_done) begin
							if (dw < 0) width_done = 1'b1;
							else width_sum = (width_sum * 10 + dw > 255) ? 255 : width_sum * 10 + dw;
						end
						if (!plain_done) begin
							if (dv < 0) plain_done = 1'b1;
							else plain_value = mac_sat(plain_value, r, dv);
						end
					end
				end
				PH_BASE: begin
					case (c)
						CH_B:    lit_base = BASE_BIN;
						CH_O:    lit_base = BASE_OCT;
						CH_D:    lit_base = BASE_DEC;
						CH_H:    lit_base = BASE_HEX;
						default: lit_base = BASE_NONE;
					endcase
					lit_phase = PH_DIGITS;
				end
				default: begin
					if (lit_base != BASE_NONE && !sized_done) begin
						r = radix_of_sel(lit_base);
						dv = char_digit(c, r);
						if (dv < 0) sized_done = 1'b1;
						else sized_value = mac_sat(sized_value, r, dv);
					end
				end
			endcase
		end
		if (!fin) return;

		if (lit_phase == PH_PREFIX) begin
			w = int'(cfg_width);
			v = plain_value;
		end else begin
			w = width_sum;
			v = (lit_base != BASE_NONE) ? sized_value : '0;
		end
		err = ERR_OK;
		if (lit_phase == PH_BASE) err = ERR_NO_BASE;
		else if (w == 0 || w > MAX_BITS) err = ERR_WIDTH;
		res.err = err;
		if (err != ERR_OK) begin
			res.value = '0;
			res.bit_width = '0;
		end else begin
			res.value = (w >= VALUE_W) ? v : v & ((VALUE_W'(1) << w) - 1);
			res.bit_width = WIDTH_W'(w);
		end
		expected_literals.push_back(res);

		lit_phase = PH_PREFIX;
		width_sum = 0;
		width_done = 1'b0;
		plain_value = '0;
		plain_done = 1'b0;
		lit_base = BASE_NONE;
		sized_value = '0;
		sized_done = 1'b0;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(int radix);
		int d;
		d = $urandom_range(0, radix - 1);
		if (d < 10) return CH_0 + CHAR_W'(d);
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + CHAR_W'(d - 10);
	endfunction

	function automatic logic [CHAR_W-1:0] junk_char();
		string j;
		j = " -+'.xzG";
		return j[$urandom_range(0, j.len() - 1)];
	endfunction

	function automatic void push_text(logic [CHAR_W-1:0] text[$]);
		char_word_t w;
		foreach (text[i]) begin
			w.code = text[i];
			w.last = (i == text.size() - 1);
			char_queue.push_back(w);
		end
	endfunction

	function automatic void push_string(string s);
		logic [CHAR_W-1:0] text[$];
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
		push_text(text);
	endfunction

	// one literal of random shape, returns the number of words queued
	function automatic int add_random_literal();
		logic [CHAR_W-1:0] text[$];
		string s;
		string others;
		int kind;
		int n;
		int r;
		int bad_at;
		kind = $urandom_range(0, 99);
		if (kind < 68) begin
			n = $urandom_range(0, 19);
			if (n == 0) s = "";
			else if (n == 1) s = "0";
			else if (n <= 3) s = $sformatf("%0d", $urandom_range(65, 99999));
			else s = $sformatf("%0d", $urandom_range(1, 64));
			for (int i = 0; i < s.len(); i++) begin
				if ($urandom_range(0, 11) == 0) text.push_back(CH_UNDERSCORE);
				text.push_back(s[i]);
			end
			text.push_back(CH_TICK);
			n = $urandom_range(0, 15);
			if (n < 12) begin
				text.push_back(BASE_CHARS[n % 4]);
				r = BASE_RADIX[n % 4];
			end else begin
				others = "BHxD'z";
				text.push_back(n == 15 ? CHAR_W'($urandom_range(0, 255)) :
					others[$urandom_range(0, others.len() - 1)]);
				r = 16;
			end
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 8);
			bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : -1;
			for (int i = 0; i < n; i++) begin
				if (i == bad_at) text.push_back(junk_char());
				if ($urandom_range(0, 5) == 0) text.push_back(CH_UNDERSCORE);
				text.push_back(digit_char(r));
			end
			if (bad_at == n) text.push_back(junk_char());
		end else if (kind < 84) begin
			// no tick: digits in the default base, now and then in another one
			r = ($urandom_range(0, 4) == 0) ? BASE_RADIX[$urandom_range(0, 3)] :
				radix_of_default(cfg_base);
			case ($urandom_range(0, 7))
				0: text.push_back(" ");
				1: text.push_back("-");
				2: begin
					text.push_back(CH_0);
					text.push_back("x");
				end
				default: ;
			endcase
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 5) == 0) text.push_back(CH_UNDERSCORE);
				text.push_back(digit_char(r));
			end
		end else if (kind < 92) begin
			// literal ends at the tick or with only underscores after it
			if ($urandom_range(0, 3) != 0) begin
				s = $sformatf("%0d", $urandom_range(1, 64));
				for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
			end
			text.push_back(CH_TICK);
			n = $urandom_range(0, 2);
			repeat (n) text.push_back(CH_UNDERSCORE);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) text.push_back(CHAR_W'($urandom_range(0, 255)));
		end
		if (text.size() == 0 || $urandom_range(0, 15) == 0) text.push_back(CH_UNDERSCORE);
		push_text(text);
		return text.size();
	endfunction

	task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PLAIN_WIDTH: cfg_width = data[WIDTH_W-1:0];
			REG_PLAIN_BASE:  cfg_base = radix_t'(data[1:0]);
		endcase
	endtask

	// block is idle once every word went in and every result came out
	task automatic wait_drained();
		while (char_queue.size() != 0 || chars.valid || expected_literals.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// word sender
	always @(negedge clk) begin
		char_word_t w;
		logic send;
		if (running && (!chars.valid || char_taken)) begin
			char_taken = 1'b0;
			send = 1'b0;
			w = '0;
			if (send_gap != 0) begin
				send_gap--;
			end else if (char_queue.size() != 0) begin
				if (!quiet && $urandom_range(1, idle_odds) == 1) begin
					send_gap = $urandom_range(0, 12);
				end else begin
					w = char_queue.pop_front();
					send = 1'b1;
				end
			end
			chars.valid <= send;
			if (send) begin
				chars.char_code <= w.code;
				chars.last <= w.last;
			end
		end
	end

	always @(posedge clk) begin
		if (running && chars.valid && chars.ready) begin
			char_taken = 1'b1;
			parse_literal_char(chars.char_code, chars.last);
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (running) begin
			if (stall_left != 0) begin
				stall_left--;
				results.ready <= 1'b0;
			end else if (!quiet && $urandom_range(1, idle_odds) == 1) begin
				stall_left = $urandom_range(0, 12);
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		literal_result_t got;
		literal_result_t want;
		if (running && results.valid && results.ready) begin
			got.value = results.value;
			got.bit_width = results.bit_width;
			got.err = results.error_code;
			if (expected_literals.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected result: value %h width %0d err %0d",
						got.value, got.bit_width, got.err);
			end else begin
				want = expected_literals.pop_front();
				if (got.value !== want.value || got.bit_width !== want.bit_width ||
						got.err !== want.err) begin
					bad_count++;
					if (bad_count <= 10)
						$display("mismatch: want %h/%0d/%0d got %h/%0d/%0d",
							want.value, want.bit_width, want.err,
							got.value, got.bit_width, got.err);
				end
			end
		end
	end

	initial begin
		int added;
		chars.valid = 1'b0;
		chars.char_code = '0;
		chars.last = 1'b0;
		results.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		running = 1'b1;

		// hex with mixed case, tick at the end, empty width, unknown base,
		// lone underscore, extreme char codes, underscore after base, leading blank
		push_string("8'hfF");
		push_string("4'");
		push_string("'b1");
		push_string("3'x7");
		push_string("_");
		push_text('{8'h00, 8'hFF});
		push_string("9'o_7");
		push_string(" 12");
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			cfg_write(REG_PLAIN_WIDTH, DATA_W'(PHASE_WIDTH[p]));
			cfg_write(REG_PLAIN_BASE, DATA_W'(PHASE_BASE[p]));
			quiet = (p == N_PHASES - 1);
			idle_odds = $urandom_range(3, 30);
			added = 0;
			while (added < 205) added += add_random_literal();
			wait_drained();
		end

		if (expected_literals.size() != 0)
			$display("%0d results never arrived", expected_literals.size());
		if (bad_count == 0 && expected_literals.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ verilog_literal_parser_unit.f @@
sv/vlp_pkg.sv
sv/vlp_ifs.sv
sv/vlp_accum.sv
sv/vlp_regs.sv
sv/vlp_scan.sv
sv/verilog_literal_parser_unit.sv
sv/vlp_checker.sv
tb/verilog_literal_parser_unit_tb.sv
